FILE: src/pol_pkg.sv
// Shared codes, widths and the result bundle for the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

   localparam int FIELD_W     = 32;
   localparam int ENTRY_W     = 2 * FIELD_W;
   localparam int CNT_FIELD_W = 5;
   localparam int POS_W       = 4;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_ZERO_DEN = 2'd3;

   typedef struct packed {
      logic [1:0]               status;
      logic [CNT_FIELD_W-1:0]   entry_count;
      logic signed [FIELD_W-1:0] read_numerator;
      logic signed [FIELD_W-1:0] read_denominator;
   } result_type;

endpackage

FILE: src/pol_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pol_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pol_engine.sv
// Command sequencer: checks, count update and entry shifting through the list RAM.
`timescale 1ns / 1ps

module pol_engine #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [pol_pkg::POS_W-1:0]         req_position,
   input  logic signed [pol_pkg::FIELD_W-1:0] req_numerator,
   input  logic signed [pol_pkg::FIELD_W-1:0] req_denominator,
   output logic                              res_valid,
   output pol_pkg::result_type               res,
   input  logic                              res_take
);

   import pol_pkg::*;

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SHIFT  = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_FINAL  = 3'd3;
   localparam logic [2:0] S_RDWAIT = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      stop_ff, stop_in;
   logic               down_ff, down_in;       // 1: insert, entries move up in address
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [ENTRY_W-1:0] new_entry_ff, new_entry_in;
   logic [1:0]         status_ff, status_in;
   logic [FIELD_W-1:0] rnum_ff, rnum_in;
   logic [FIELD_W-1:0] rden_ff, rden_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic [XW-1:0]      pos_x;
   logic [XW-1:0]      cnt_x;
   logic [XW-1:0]      last_x;
   logic [XW-1:0]      slot_x;

   pol_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pos_x  = XW'(req_position);
   assign cnt_x  = XW'(count_ff);
   assign last_x = cnt_x - XW'(1);

   // insert goes after min(position, count-1); front when empty or position 0
   always_comb begin
      if (count_ff == '0 || req_position == '0) begin
         slot_x = '0;
      end else if (pos_x < last_x) begin
         slot_x = pos_x + XW'(1);
      end else begin
         slot_x = cnt_x;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      down_in      = down_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      slot_in      = slot_ff;
      new_entry_in = new_entry_ff;
      status_in    = status_ff;
      rnum_in      = rnum_ff;
      rden_in      = rden_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = new_entry_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in    = ST_OK;
               rnum_in      = '0;
               rden_in      = '0;
               state_in     = S_RESP;
               new_entry_in = {req_denominator, req_numerator};
               slot_in      = AW'(slot_x);
               pend_in      = 1'b0;
               unique case (req_command)
                  CMD_INSERT: begin
                     if (req_denominator == '0) begin
                        status_in = ST_ZERO_DEN;
                     end else if (count_ff == CW'(LIST_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        if (slot_x == cnt_x) begin
                           // append: nothing to move, write straight away
                           wr_en   = 1'b1;
                           wr_addr = AW'(slot_x);
                           wr_data = {req_denominator, req_numerator};
                        end else begin
                           ptr_in   = AW'(last_x);
                           stop_in  = AW'(slot_x);
                           down_in  = 1'b1;
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_x >= cnt_x) begin
                        status_in = ST_RANGE;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (pos_x != last_x) begin
                           ptr_in   = AW'(pos_x + XW'(1));
                           stop_in  = AW'(last_x);
                           down_in  = 1'b0;
                           state_in = S_SHIFT;
                        end
                     end
                  end
                  CMD_READ: begin
                     if (pos_x >= cnt_x) begin
                        status_in = ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(pos_x);
                        state_in = S_RDWAIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // read one entry per cycle, write the previous one to its new slot
            rd_en        = 1'b1;
            rd_addr      = ptr_ff;
            wr_en        = pend_ff;
            wr_addr      = pend_addr_ff;
            wr_data      = rd_data;
            pend_in      = 1'b1;
            pend_addr_in = down_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
            if (ptr_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = down_ff ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            wr_en    = 1'b1;
            wr_addr  = pend_addr_ff;
            wr_data  = rd_data;
            pend_in  = 1'b0;
            state_in = down_ff ? S_FINAL : S_RESP;
         end
         S_FINAL: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = new_entry_ff;
            state_in = S_RESP;
         end
         S_RDWAIT: begin
            rnum_in  = rd_data[FIELD_W-1:0];
            rden_in  = rd_data[ENTRY_W-1:FIELD_W];
            state_in = S_RESP;
         end
         S_RESP: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      stop_ff      <= stop_in;
      down_ff      <= down_in;
      pend_addr_ff <= pend_addr_in;
      slot_ff      <= slot_in;
      new_entry_ff <= new_entry_in;
      status_ff    <= status_in;
      rnum_ff      <= rnum_in;
      rden_ff      <= rden_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign res_valid            = (state_ff == S_RESP);
   assign res.status           = status_ff;
   assign res.entry_count      = CNT_FIELD_W'(count_ff);
   assign res.read_numerator   = rnum_ff;
   assign res.read_denominator = rden_ff;

endmodule

FILE: src/positional_ordered_list.sv
// Top level of the positional ordered list with its output register.
`timescale 1ns / 1ps

// Ordered list of up to LIST_DEPTH fraction entries (32-bit numerator and
// denominator) kept in one RAM. Commands arrive on the req_ channel (insert,
// delete at position, read at position); each produces one rsp_ word with a
// status, the entry count after the command and, for a good read, the entry.
// Both channels move a word on a clock edge with valid high and stall low.
// One command is worked at a time; req_stall is high while one is in flight
// and drops in the cycle that rsp_valid rises, so the next command can start.
// A rejected command, an append or a delete of the last entry goes straight
// to the response state; a read passes through S_RDWAIT for the registered
// RAM data; a middle insert or delete moves entries (S_SHIFT, S_DRAIN), and
// an insert then writes the new entry in S_FINAL.
// Moving entries costs one cycle each, bounded by the single RAM read and
// write port; an insert at the front of a full-minus-one list moves
// LIST_DEPTH - 1 entries. A finished word waits in the output register while
// rsp_stall is high; the engine holds its next result until that register
// frees up. Synchronous reset empties the list and drops rsp_valid; the RAM
// contents are not cleared, since only entries below the count are read.
module positional_ordered_list #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [pol_pkg::POS_W-1:0]         req_position,
   input  logic signed [pol_pkg::FIELD_W-1:0] req_numerator,
   input  logic signed [pol_pkg::FIELD_W-1:0] req_denominator,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [pol_pkg::CNT_FIELD_W-1:0]   rsp_entry_count,
   output logic signed [pol_pkg::FIELD_W-1:0] rsp_read_numerator,
   output logic signed [pol_pkg::FIELD_W-1:0] rsp_read_denominator
);

   import pol_pkg::*;

   logic       res_valid;
   logic       res_take;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   pol_engine #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .res_valid       (res_valid),
      .res             (res),
      .res_take        (res_take)
   );

   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      priority if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_entry_count      = rsp_ff.entry_count;
   assign rsp_read_numerator   = rsp_ff.read_numerator;
   assign rsp_read_denominator = rsp_ff.read_denominator;

endmodule

FILE: src/pol_checker.sv
// Port-level checks for the positional ordered list, bound to the top level.
`timescale 1ns / 1ps

module pol_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [1:0]                        rsp_status,
   input logic signed [pol_pkg::FIELD_W-1:0] rsp_read_numerator,
   input logic signed [pol_pkg::FIELD_W-1:0] rsp_read_denominator
);

   import pol_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // one command in flight: the cycle after a word is taken the input stalls
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken while one is in flight");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_read_numerator == '0 && rsp_read_denominator == '0)
      else $error("read fields nonzero on a rejected command");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_read_numerator))
      else $error("stalled response word changed");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

FILE: bench/positional_ordered_list_checker.sv
// Checker for the positional ordered list: predicts each response word and compares it.
`timescale 1ns / 1ps

module positional_ordered_list_checker #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [pol_pkg::POS_W-1:0]         req_position,
   input  logic signed [pol_pkg::FIELD_W-1:0] req_numerator,
   input  logic signed [pol_pkg::FIELD_W-1:0] req_denominator,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_status,
   input  logic [pol_pkg::CNT_FIELD_W-1:0]   rsp_entry_count,
   input  logic signed [pol_pkg::FIELD_W-1:0] rsp_read_numerator,
   input  logic signed [pol_pkg::FIELD_W-1:0] rsp_read_denominator,
   output int                                bad_words,
   output int                                words_due
);
   import pol_pkg::*;

   typedef struct packed {
      logic signed [FIELD_W-1:0] den;
      logic signed [FIELD_W-1:0] num;
   } fraction_type;

   fraction_type fractions [LIST_DEPTH];
   int           list_len;
   result_type   due_words [$];
   result_type   arrived;
   result_type   oldest;

   // Shadow list: applies one command and returns the word the block owes for it.
   function automatic result_type apply_list_command(
      input logic [1:0]         cmd,
      input logic [POS_W-1:0]   pos,
      input logic signed [FIELD_W-1:0] num,
      input logic signed [FIELD_W-1:0] den
   );
      result_type word;
      int         slot;
      int         i;
      word = '0;
      word.status = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (den == 0) begin
               word.status = ST_ZERO_DEN;
            end else if (list_len >= LIST_DEPTH) begin
               word.status = ST_FULL;
            end else begin
               // nonzero position lands after element min(pos, len-1)
               if (list_len == 0 || pos == 0)
                  slot = 0;
               else
                  slot = ((int'(pos) < list_len - 1) ? int'(pos) : list_len - 1) + 1;
               for (i = list_len; i > slot; i--)
                  fractions[i] = fractions[i-1];
               fractions[slot].num = num;
               fractions[slot].den = den;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (int'(pos) >= list_len) begin
               word.status = ST_RANGE;
            end else begin
               for (i = int'(pos); i + 1 < list_len; i++)
                  fractions[i] = fractions[i+1];
               list_len--;
            end
         end
         CMD_READ: begin
            if (int'(pos) >= list_len) begin
               word.status = ST_RANGE;
            end else begin
               word.read_numerator   = fractions[pos].num;
               word.read_denominator = fractions[pos].den;
            end
         end
         default: ;
      endcase
      word.entry_count = list_len[CNT_FIELD_W-1:0];
      return word;
   endfunction

   task automatic compare_field(
      input string       field_name,
      input logic [31:0] expected_value,
      input logic [31:0] actual_value
   );
      if (expected_value !== actual_value) begin
         $error("%s: expected %0h, got %0h", field_name, expected_value, actual_value);
         bad_words++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_words.delete();
         list_len = 0;
         words_due <= 0;
      end else begin
         // a response always belongs to an earlier command, so check it first
         if (rsp_valid && !rsp_stall) begin
            arrived.status           = rsp_status;
            arrived.entry_count      = rsp_entry_count;
            arrived.read_numerator   = rsp_read_numerator;
            arrived.read_denominator = rsp_read_denominator;
            if (due_words.size() == 0) begin
               $error("word with none due: status %0d, count %0d",
                      rsp_status, rsp_entry_count);
               bad_words++;
            end else begin
               oldest = due_words.pop_front();
               compare_field("status", 32'(oldest.status), 32'(arrived.status));
               compare_field("entry_count", 32'(oldest.entry_count),
                             32'(arrived.entry_count));
               compare_field("read_numerator", oldest.read_numerator,
                             arrived.read_numerator);
               compare_field("read_denominator", oldest.read_denominator,
                             arrived.read_denominator);
            end
         end
         if (req_valid && !req_stall)
            due_words.push_back(apply_list_command(req_command, req_position,
                                                   req_numerator, req_denominator));
         words_due <= due_words.size();
      end
   end

endmodule

FILE: bench/positional_ordered_list_test.sv
// Top of the positional ordered list bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module positional_ordered_list_test;
   import pol_pkg::*;

   localparam int         LIST_DEPTH  = 16;
   localparam int         PHASE_WORDS = 307;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_command = CMD_INSERT;
   logic [POS_W-1:0]           req_position = '0;
   logic signed [FIELD_W-1:0]  req_numerator = '0;
   logic signed [FIELD_W-1:0]  req_denominator = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_status;
   logic [CNT_FIELD_W-1:0]     rsp_entry_count;
   logic signed [FIELD_W-1:0]  rsp_read_numerator;
   logic signed [FIELD_W-1:0]  rsp_read_denominator;

   int bad_words;
   int words_due;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   positional_ordered_list #(
      .LIST_DEPTH(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_position(req_position),
      .req_numerator(req_numerator),
      .req_denominator(req_denominator),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_read_numerator(rsp_read_numerator),
      .rsp_read_denominator(rsp_read_denominator)
   );

   positional_ordered_list_checker #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_position(req_position),
      .req_numerator(req_numerator),
      .req_denominator(req_denominator),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_read_numerator(rsp_read_numerator),
      .rsp_read_denominator(rsp_read_denominator),
      .bad_words(bad_words),
      .words_due(words_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Lowers valid for random idle gaps before the word, then raises it with the word's fields.
   task automatic send_word(
      input logic [1:0]        cmd,
      input logic [POS_W-1:0]  pos,
      input logic [FIELD_W-1:0] num,
      input logic [FIELD_W-1:0] den
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_position    <= pos;
      req_numerator   <= num;
      req_denominator <= den;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_list_words;
      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   task automatic send_random_word(input bit filling);
      logic [1:0]         cmd;
      logic [POS_W-1:0]   pos;
      logic [FIELD_W-1:0] num;
      logic [FIELD_W-1:0] den;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 3)
         cmd = CMD_UNUSED;
      else if (filling)
         cmd = (pick < 70) ? CMD_INSERT : (pick < 85) ? CMD_DELETE : CMD_READ;
      else
         cmd = (pick < 18) ? CMD_INSERT : (pick < 65) ? CMD_DELETE : CMD_READ;
      // favor low positions so short lists still see in-range deletes and reads
      pos = $urandom_range(1) ? POS_W'($urandom_range(15)) : POS_W'($urandom_range(3));
      case ($urandom_range(7))
         0:       num = 32'h8000_0000;
         1:       num = 32'h7fff_ffff;
         default: num = $urandom;
      endcase
      case ($urandom_range(15))
         0:       den = 32'h0;
         1:       den = 32'h8000_0000;
         2:       den = 32'hffff_ffff;
         default: den = $urandom;
      endcase
      send_word(cmd, pos, num, den);
   endtask

   initial begin
      int  k;
      int  n;
      int  phase;
      bit  filling;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, extremes, front/tail/middle inserts, unused command
      send_word(CMD_READ, 4'd0, 32'h0, 32'h0);
      send_word(CMD_DELETE, 4'd3, 32'h0, 32'h0);
      send_word(CMD_INSERT, 4'd0, 32'h1234_5678, 32'h0);
      send_word(CMD_INSERT, 4'd9, 32'h7fff_ffff, 32'h8000_0000);
      send_word(CMD_INSERT, 4'd0, 32'h8000_0000, 32'h7fff_ffff);
      send_word(CMD_INSERT, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
      send_word(CMD_INSERT, 4'd1, 32'h0, 32'h1);
      send_word(CMD_UNUSED, 4'd5, 32'hdead_beef, 32'hcafe_f00d);
      send_word(CMD_READ, 4'd3, 32'h0, 32'h0);
      send_word(CMD_READ, 4'd4, 32'h0, 32'h0);
      // removing the tail makes the one before it the new tail
      send_word(CMD_DELETE, 4'd3, 32'h0, 32'h0);
      send_word(CMD_READ, 4'd2, 32'h0, 32'h0);
      for (k = 0; k < 13; k++)
         send_word(CMD_INSERT, 4'($urandom_range(15)), $urandom, $urandom | 32'h1);
      send_word(CMD_INSERT, 4'd2, 32'h5555_aaaa, 32'haaaa_5555);
      // zero denominator wins over full
      send_word(CMD_INSERT, 4'd2, 32'h5555_aaaa, 32'h0);
      send_word(CMD_DELETE, 4'd15, 32'h0, 32'h0);
      send_word(CMD_READ, 4'd15, 32'h0, 32'h0);
      send_word(CMD_DELETE, 4'd0, 32'h0, 32'h0);
      send_word(CMD_DELETE, 4'd5, 32'h0, 32'h0);
      drain_list_words();

      filling = 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 67 : 0;
         recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 36 : 0;
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0)
               filling = !filling;
            send_random_word(filling);
         end
         drain_list_words();
      end

      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (bad_words == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
